// ===== src/vubn_pkg.sv =====
`timescale 1ns / 1ps

package vubn_pkg;

  // Geometry of one vertex and of a set
  localparam int AXES      = 3;
  localparam int AX_W      = 2;
  localparam int CRD_MAX_W = 32;
  localparam int CNT_MAX_W = 7;

  // Target cube edge, unsigned Q15.16
  localparam int TBS_W = 31;
  localparam logic [TBS_W-1:0] TBS_RESET = 31'd65536;

  // One closed set as handed from the load side to the emit side
  typedef struct packed {
    logic [CNT_MAX_W-1:0]                count;
    logic                                overflow;
    logic [AXES-1:0][CRD_MAX_W-1:0]      box_min;
    logic [AXES-1:0][CRD_MAX_W-1:0]      box_max;
  } job_t;

endpackage

// ===== src/vubn_ram.sv =====
`timescale 1ns / 1ps

module vubn_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/vubn_queue.sv =====
`timescale 1ns / 1ps

module vubn_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vubn_pkg::job_t job_i,
  input  logic           pop_i,
  output vubn_pkg::job_t job_o,
  output logic           wr_slot_o,
  output logic           rd_slot_o,
  output logic           full_o,
  output logic           empty_o
);

  import vubn_pkg::*;

  job_t       slot_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;

  // Hold the set descriptors; the slot number also picks the store bank
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= job_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign job_o     = slot_q[rptr_q];
  assign wr_slot_o = wptr_q;
  assign rd_slot_o = rptr_q;
  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);

endmodule

// ===== src/vubn_front.sv =====
`timescale 1ns / 1ps

module vubn_front #(
  parameter int VERTEX_DEPTH = 64,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [31:0]      pos_x_i,
  input  logic signed [31:0]      pos_y_i,
  input  logic signed [31:0]      pos_z_i,
  input  logic                    final_vertex_i,
  input  logic                    full_i,
  input  logic                    wr_slot_i,
  output logic                    push_o,
  output vubn_pkg::job_t          job_o,
  output logic                    we_o,
  output logic [((VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1):0] waddr_o,
  output logic [3*COORD_WIDTH-1:0] wdata_o
);

  import vubn_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int IW   = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int CNTW = $clog2(VERTEX_DEPTH + 1);
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  logic [CNTW-1:0]      count_q, count_d;
  logic                 overflow_q, overflow_d;
  logic signed [CW-1:0] min_q [AXES];
  logic signed [CW-1:0] min_d [AXES];
  logic signed [CW-1:0] max_q [AXES];
  logic signed [CW-1:0] max_d [AXES];
  logic signed [CW-1:0] coord [AXES];
  logic                 accept;
  logic                 room;

  assign coord[0] = pos_x_i[CW-1:0];
  assign coord[1] = pos_y_i[CW-1:0];
  assign coord[2] = pos_z_i[CW-1:0];

  // Stall only while both store banks hold sets not yet fully emitted
  assign busy_o = full_i;
  assign accept = start_i && !full_i;
  assign room   = (count_q != CNTW'(VERTEX_DEPTH));

  // Fold the beat into the box, or mark it dropped when the bank is full
  always_comb begin
    count_d    = count_q;
    overflow_d = overflow_q;
    min_d      = min_q;
    max_d      = max_q;
    if (accept) begin
      if (room) begin
        for (int a = 0; a < AXES; a++) begin
          if (coord[a] < min_q[a]) begin
            min_d[a] = coord[a];
          end
          if (coord[a] > max_q[a]) begin
            max_d[a] = coord[a];
          end
        end
        count_d = count_q + CNTW'(1);
      end else begin
        overflow_d = 1'b1;
      end
    end
  end

  // Hand the closed set to the emit side
  assign push_o = accept && final_vertex_i;

  always_comb begin
    job_o.count    = CNT_MAX_W'(count_d);
    job_o.overflow = overflow_d;
    for (int a = 0; a < AXES; a++) begin
      job_o.box_min[a] = CRD_MAX_W'(min_d[a]);
      job_o.box_max[a] = CRD_MAX_W'(max_d[a]);
    end
  end

  // Write the vertex into the bank being filled
  assign we_o    = accept && room;
  assign waddr_o = {wr_slot_i, count_q[IW-1:0]};
  assign wdata_o = {coord[2], coord[1], coord[0]};

  // Hold the set state; clear it once the set is handed off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        min_q[a] <= COORD_MAX;
        max_q[a] <= COORD_MIN;
      end
    end else if (push_o) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        min_q[a] <= COORD_MAX;
        max_q[a] <= COORD_MIN;
      end
    end else begin
      count_q    <= count_d;
      overflow_q <= overflow_d;
      min_q      <= min_d;
      max_q      <= max_d;
    end
  end

endmodule

// ===== src/vubn_back.sv =====
`timescale 1ns / 1ps

module vubn_back #(
  parameter int VERTEX_DEPTH = 64,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vubn_pkg::job_t           job_i,
  input  logic                     empty_i,
  input  logic                     rd_slot_i,
  input  logic [30:0]              tbs_i,
  output logic                     pop_o,
  output logic                     re_o,
  output logic [((VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1):0] raddr_o,
  input  logic [3*COORD_WIDTH-1:0] rdata_i,
  output logic                     valid_o,
  output logic signed [31:0]       norm_x_o,
  output logic signed [31:0]       norm_y_o,
  output logic signed [31:0]       norm_z_o,
  output logic                     last_o,
  output logic                     degenerate_o,
  output logic                     saturated_o,
  output logic                     truncated_o
);

  import vubn_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int IW   = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int CNTW = $clog2(VERTEX_DEPTH + 1);
  localparam int OW   = CW + 2;
  localparam int PW   = CW + TBS_W;
  localparam int NW   = PW + 1;
  localparam int HW   = NW - CW;
  localparam int BW   = $clog2(CW);
  localparam logic [AX_W-1:0] LAST_AX = AX_W'(AXES - 1);
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_EXTENT, S_READ, S_MUL, S_ADD, S_PRE, S_DIV, S_FIN
  } state_e;

  state_e             state_q;
  logic [AX_W-1:0]    ax_q;
  logic [IW-1:0]      idx_q;
  logic [BW-1:0]      step_q;
  logic               valid_q;
  logic signed [31:0] norm_x_q, norm_y_q, norm_z_q;
  logic               last_q, degenerate_q, saturated_q, truncated_q;

  // Datapath registers
  logic [CW-1:0]        dm_q;
  logic [PW-1:0]        prod_q;
  logic [NW-1:0]        num_q;
  logic [CW:0]          rem_q;
  logic [CW-1:0]        low_q;
  logic [CW-1:0]        q_q;
  logic                 neg_q;
  logic                 ovf_q;
  logic                 sat_acc_q;
  logic signed [31:0]   res_x_q, res_y_q;

  logic signed [CW-1:0] vtx [AXES];
  logic [CW-1:0]        ext [AXES];
  logic [CW-1:0]        dm_c;
  logic                 dm_zero;
  logic signed [CW-1:0] v_sel, mn_sel, mx_sel;
  logic signed [OW-1:0] off2;
  logic                 neg_c;
  logic [OW-1:0]        abs_c;
  logic [CW-1:0]        mag_c;
  logic [HW-1:0]        hi;
  logic                 over_c;
  logic [CW+1:0]        trial;
  logic [CW+1:0]        dvs;
  logic                 ge;
  logic [CW:0]          rem_next;
  logic                 clamp_c;
  logic signed [CW-1:0] res_c;
  logic                 last_c;

  // Split the read beat into axes
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      vtx[a] = rdata_i[a*CW +: CW];
    end
  end

  // Largest per-axis extent of the set
  always_comb begin
    dm_c = '0;
    for (int a = 0; a < AXES; a++) begin
      ext[a] = job_i.box_max[a][CW-1:0] - job_i.box_min[a][CW-1:0];
      if (ext[a] > dm_c) begin
        dm_c = ext[a];
      end
    end
  end

  assign dm_zero = (dm_q == '0);

  // Twice the offset from the box center, as sign and magnitude
  assign v_sel  = vtx[ax_q];
  assign mn_sel = job_i.box_min[ax_q][CW-1:0];
  assign mx_sel = job_i.box_max[ax_q][CW-1:0];
  assign off2   = (OW'(v_sel) <<< 1) - OW'(mn_sel) - OW'(mx_sel);
  assign neg_c  = off2[OW-1];
  assign abs_c  = neg_c ? (~off2 + OW'(1)) : off2;
  assign mag_c  = abs_c[CW-1:0];

  // A quotient of 2^CW or more clamps without dividing
  assign hi     = num_q[NW-1:CW];
  assign over_c = (NW'(hi) >= NW'({dm_q, 1'b0}));

  // One restoring division step by twice the extent
  assign trial    = {rem_q, low_q[CW-1]};
  assign dvs      = {1'b0, dm_q, 1'b0};
  assign ge       = (trial >= dvs);
  assign rem_next = (CW+1)'(ge ? (trial - dvs) : trial);

  // Apply sign and clamp to the coordinate range
  always_comb begin
    if (neg_q) begin
      clamp_c = ovf_q || (q_q[CW-1] && (|q_q[CW-2:0]));
    end else begin
      clamp_c = ovf_q || q_q[CW-1];
    end
    if (clamp_c) begin
      res_c = neg_q ? COORD_MIN : COORD_MAX;
    end else begin
      res_c = neg_q ? (~q_q + CW'(1)) : q_q;
    end
  end

  assign last_c = ((CNTW'(idx_q) + CNTW'(1)) == job_i.count[CNTW-1:0]);

  assign pop_o   = (state_q == S_FIN) && (ax_q == LAST_AX) && last_c;
  assign re_o    = (state_q == S_READ);
  assign raddr_o = {rd_slot_i, idx_q};

  // Sequence reads, axes and division steps; drive the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ax_q         <= '0;
      idx_q        <= '0;
      step_q       <= '0;
      valid_q      <= 1'b0;
      norm_x_q     <= '0;
      norm_y_q     <= '0;
      norm_z_q     <= '0;
      last_q       <= 1'b0;
      degenerate_q <= 1'b0;
      saturated_q  <= 1'b0;
      truncated_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            state_q <= S_EXTENT;
          end
        end
        S_EXTENT: begin
          idx_q   <= '0;
          state_q <= S_READ;
        end
        S_READ: begin
          ax_q    <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= dm_zero ? S_FIN : S_ADD;
        end
        S_ADD: begin
          state_q <= S_PRE;
        end
        S_PRE: begin
          step_q  <= BW'(CW - 1);
          state_q <= over_c ? S_FIN : S_DIV;
        end
        S_DIV: begin
          if (step_q == '0) begin
            state_q <= S_FIN;
          end else begin
            step_q <= step_q - BW'(1);
          end
        end
        S_FIN: begin
          if (ax_q == LAST_AX) begin
            valid_q      <= 1'b1;
            norm_x_q     <= res_x_q;
            norm_y_q     <= res_y_q;
            norm_z_q     <= CRD_MAX_W'(res_c);
            last_q       <= last_c;
            degenerate_q <= dm_zero;
            saturated_q  <= sat_acc_q | clamp_c;
            truncated_q  <= job_i.overflow;
            if (last_c) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + IW'(1);
              state_q <= S_READ;
            end
          end else begin
            ax_q    <= ax_q + AX_W'(1);
            state_q <= S_MUL;
          end
        end
      endcase
    end
  end

  // Datapath: extent, product, numerator, quotient bits, per-axis results
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_EXTENT: begin
        dm_q <= dm_c;
      end
      S_READ: begin
        sat_acc_q <= 1'b0;
      end
      S_MUL: begin
        neg_q  <= neg_c && !dm_zero;
        prod_q <= PW'(mag_c) * PW'(tbs_i);
        q_q    <= '0;
        ovf_q  <= 1'b0;
      end
      S_ADD: begin
        num_q <= NW'(prod_q) + NW'(dm_q);
      end
      S_PRE: begin
        ovf_q <= over_c;
        rem_q <= (CW+1)'(hi);
        low_q <= num_q[CW-1:0];
      end
      S_DIV: begin
        rem_q <= rem_next;
        low_q <= low_q << 1;
        q_q   <= {q_q[CW-2:0], ge};
      end
      S_FIN: begin
        sat_acc_q <= sat_acc_q | clamp_c;
        if (ax_q == AX_W'(0)) begin
          res_x_q <= CRD_MAX_W'(res_c);
        end else if (ax_q == AX_W'(1)) begin
          res_y_q <= CRD_MAX_W'(res_c);
        end
      end
      default: begin
      end
    endcase
  end

  assign valid_o      = valid_q;
  assign norm_x_o     = norm_x_q;
  assign norm_y_o     = norm_y_q;
  assign norm_z_o     = norm_z_q;
  assign last_o       = last_q;
  assign degenerate_o = degenerate_q;
  assign saturated_o  = saturated_q;
  assign truncated_o  = truncated_q;

endmodule

// ===== src/vertex_unit_box_normalizer.sv =====
`timescale 1ns / 1ps

// Vertex normalizer to a cube of edge target_box_size. Vertices (signed Q16.16)
// are taken one per cycle while start_i is high and busy_o low; the one
// marked final_vertex_i closes the set. The closed set is then emitted in load
// order, centered and scaled by target_box_size / (largest extent), rounded to
// nearest with ties away from zero and clamped. Two store banks let the next
// set load while the previous one is being emitted; busy_o rises only while
// both banks hold sets not yet fully emitted. Emission runs one shared
// multiply and restoring divide over the three axes in turn; a coordinate that
// would clamp skips the divide, as do all coordinates of a degenerate set, and
// the largest extent is taken once at the start of each set. Each result is a
// single-cycle beat on result_valid_o; the receiver cannot stall it. Vertices
// beyond VERTEX_DEPTH are dropped and flagged on every result of the set. The
// configuration port is always ready; it is to be written only while the
// block is idle, which the user must ensure, as the block has no check for it.
module vertex_unit_box_normalizer #(
  parameter int VERTEX_DEPTH = 64,
  parameter int COORD_WIDTH  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic               final_vertex_i,
  output logic               result_valid_o,
  output logic signed [31:0] norm_x_o,
  output logic signed [31:0] norm_y_o,
  output logic signed [31:0] norm_z_o,
  output logic               last_result_o,
  output logic               degenerate_o,
  output logic               saturated_o,
  output logic               truncated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [30:0]        cfg_data_i
);

  import vubn_pkg::*;

  localparam int IW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int AW = IW + 1;

  logic [TBS_W-1:0]     tbs_q;
  logic                 q_push, q_pop, q_full, q_empty;
  logic                 wr_slot, rd_slot;
  job_t                 job_in, job_head;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [3*COORD_WIDTH-1:0] ram_wdata, ram_rdata;

  // Hold the target edge length
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbs_q <= TBS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tbs_q <= cfg_data_i;
    end
  end

  vubn_front #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .final_vertex_i (final_vertex_i),
    .full_i         (q_full),
    .wr_slot_i      (wr_slot),
    .push_o         (q_push),
    .job_o          (job_in),
    .we_o           (ram_we),
    .waddr_o        (ram_waddr),
    .wdata_o        (ram_wdata)
  );

  vubn_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .job_i     (job_in),
    .pop_i     (q_pop),
    .job_o     (job_head),
    .wr_slot_o (wr_slot),
    .rd_slot_o (rd_slot),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  vubn_ram #(
    .WIDTH (3 * COORD_WIDTH),
    .DEPTH (2 ** AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  vubn_back #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_head),
    .empty_i      (q_empty),
    .rd_slot_i    (rd_slot),
    .tbs_i        (tbs_q),
    .pop_o        (q_pop),
    .re_o         (ram_re),
    .raddr_o      (ram_raddr),
    .rdata_i      (ram_rdata),
    .valid_o      (result_valid_o),
    .norm_x_o     (norm_x_o),
    .norm_y_o     (norm_y_o),
    .norm_z_o     (norm_z_o),
    .last_o       (last_result_o),
    .degenerate_o (degenerate_o),
    .saturated_o  (saturated_o),
    .truncated_o  (truncated_o)
  );

`ifndef NO_ASSERTIONS
  a_beat_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beats in consecutive cycles");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && degenerate_o) |->
      (norm_x_o == 32'sd0 && norm_y_o == 32'sd0 && norm_z_o == 32'sd0 && !saturated_o))
    else $error("degenerate result carries nonzero data");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("set handed off while both banks are pending");

  a_beat_has_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(!q_empty))
    else $error("result beat without a pending set");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import vubn_pkg::*;

  localparam int VDEPTH         = 64;
  localparam int CWIDTH         = 32;
  localparam int SETTLE_CYCLES  = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 60;
  localparam int RAND_PHASES    = 4;
  localparam int PHASE_ITEMS    = 45;

  localparam logic [31:0]       CRD_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0]       CRD_MIN  = 32'h8000_0000;
  localparam logic [TBS_W-1:0]  TBS_FULL = '1;

  // How the vertices of one random set are spread
  typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_EXTREME, SPREAD_FLAT} spread_e;

  typedef struct packed {
    logic [AXES-1:0][31:0] pos;
    logic                  fin;
  } vertex_t;

  typedef struct packed {
    logic [AXES-1:0][31:0] norm;
    logic                  last;
    logic                  degen;
    logic                  sat;
    logic                  trunc;
  } norm_result_t;

  // Clock, reset and block inputs
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic final_vertex_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [30:0] cfg_data_i = '0;

  logic busy_o, result_valid_o, cfg_ready_o;
  logic signed [31:0] norm_x_o, norm_y_o, norm_z_o;
  logic last_result_o, degenerate_o, saturated_o, truncated_o;

  // Stimulus and expectation stores
  vertex_t      vertex_queue[$];
  norm_result_t expected_norms[$];
  vertex_t      cur_vertex;
  bit           holding = 1'b0;
  bit           burst = 1'b0;
  bit           go;
  int           gap_left = 0;
  int           mismatches = 0;
  int           result_idx = 0;
  int           idle_cycles = 0;
  norm_result_t got, want;
  string        axis_name[AXES] = '{"norm_x", "norm_y", "norm_z"};

  // Shadow of the block: stored set, running box, box size register
  logic [AXES-1:0][31:0] vstore[VDEPTH];
  int unsigned           vcount;
  longint                box_lo[AXES];
  longint                box_hi[AXES];
  bit                    set_overflow;
  logic [TBS_W-1:0]      box_size;

  vertex_unit_box_normalizer #(
    .VERTEX_DEPTH(VDEPTH),
    .COORD_WIDTH (CWIDTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .final_vertex_i(final_vertex_i),
    .result_valid_o(result_valid_o),
    .norm_x_o      (norm_x_o),
    .norm_y_o      (norm_y_o),
    .norm_z_o      (norm_z_o),
    .last_result_o (last_result_o),
    .degenerate_o  (degenerate_o),
    .saturated_o   (saturated_o),
    .truncated_o   (truncated_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Empty the box and the store for the next set
  function automatic void clear_set_state();
    vcount = 0;
    set_overflow = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      box_lo[a] = longint'($signed(CRD_MAX));
      box_hi[a] = longint'($signed(CRD_MIN));
    end
  endfunction

  // Center and scale one coordinate: (2v - lo - hi) * size / (2 * dm), round half away
  function automatic logic [31:0] scale_axis(longint v, int a, longint unsigned dm,
                                             inout bit clamped);
    longint          off2;
    longint unsigned mag;
    longint unsigned q;
    off2 = 2 * v - box_lo[a] - box_hi[a];
    mag = (off2 < 0) ? -off2 : off2;
    q = (mag * box_size + dm) / (2 * dm);
    if (off2 < 0) begin
      if (q > 64'd2147483648) begin
        clamped = 1'b1;
        return CRD_MIN;
      end
      return 32'(-longint'(q));
    end
    if (q > 64'd2147483647) begin
      clamped = 1'b1;
      return CRD_MAX;
    end
    return 32'(q);
  endfunction

  // Take one accepted vertex; on the closing vertex queue the whole normalized set
  function automatic void load_vertex(vertex_t v);
    longint          c;
    longint unsigned dm;
    longint unsigned d;
    norm_result_t    r;
    bit              clamped;
    if (vcount < VDEPTH) begin
      vstore[vcount] = v.pos;
      for (int a = 0; a < AXES; a++) begin
        c = longint'($signed(v.pos[a]));
        if (c < box_lo[a]) box_lo[a] = c;
        if (c > box_hi[a]) box_hi[a] = c;
      end
      vcount++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!v.fin) return;
    dm = 0;
    for (int a = 0; a < AXES; a++) begin
      d = box_hi[a] - box_lo[a];
      if (d > dm) dm = d;
    end
    for (int i = 0; i < vcount; i++) begin
      clamped = 1'b0;
      for (int a = 0; a < AXES; a++) begin
        if (dm == 0) r.norm[a] = '0;
        else r.norm[a] = scale_axis(longint'($signed(vstore[i][a])), a, dm, clamped);
      end
      r.last  = (i + 1 == vcount);
      r.degen = (dm == 0);
      r.sat   = clamped;
      r.trunc = set_overflow;
      expected_norms = {expected_norms, r};
    end
    clear_set_state();
  endfunction

  // Gap before the next vertex; flip between bursts and idling now and then
  function automatic int draw_gap();
    if ($urandom_range(0, 15) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(string field, logic [31:0] actual, logic [31:0] exp_val);
    if (actual !== exp_val)
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                result_idx, field, actual, exp_val));
  endtask

  // Drive vertices: hold each beat until accepted, then idle for a drawn gap
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      go = start_i;
      if (start_i && !busy_o) begin
        load_vertex(cur_vertex);
        holding = 1'b0;
        go = 1'b0;
        gap_left = draw_gap();
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (vertex_queue.size() > 0) begin
          cur_vertex = vertex_queue.pop_front();
          holding = 1'b1;
          go = 1'b1;
          pos_x_i <= cur_vertex.pos[0];
          pos_y_i <= cur_vertex.pos[1];
          pos_z_i <= cur_vertex.pos[2];
          final_vertex_i <= cur_vertex.fin;
        end
      end
      start_i <= go;
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_norms.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", result_idx));
      end else begin
        want = expected_norms.pop_front();
        got.norm[0] = norm_x_o;
        got.norm[1] = norm_y_o;
        got.norm[2] = norm_z_o;
        for (int a = 0; a < AXES; a++) check_field(axis_name[a], got.norm[a], want.norm[a]);
        check_field("last_result", last_result_o, want.last);
        check_field("degenerate", degenerate_o, want.degen);
        check_field("saturated", saturated_o, want.sat);
        check_field("truncated", truncated_o, want.trunc);
      end
      result_idx++;
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic fin);
    vertex_t v;
    v.pos[0] = x;
    v.pos[1] = y;
    v.pos[2] = z;
    v.fin = fin;
    vertex_queue = {vertex_queue, v};
  endtask

  // One set of n vertices, closed by the last one
  task automatic add_random_set(int n);
    spread_e     spread;
    logic [31:0] base;
    logic [31:0] crd[AXES];
    case ($urandom_range(0, 7))
      0, 1, 2, 3: spread = SPREAD_FULL;
      4, 5:       spread = SPREAD_NARROW;
      6:          spread = SPREAD_EXTREME;
      default:    spread = SPREAD_FLAT;
    endcase
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      for (int a = 0; a < AXES; a++) begin
        case (spread)
          SPREAD_FULL:   crd[a] = $urandom;
          SPREAD_NARROW: crd[a] = base + 32'(a * 1000) + $urandom_range(0, 63);
          SPREAD_FLAT:   crd[a] = base + 32'(a);
          default: begin
            case ($urandom_range(0, 4))
              0:       crd[a] = CRD_MIN;
              1:       crd[a] = CRD_MAX;
              2:       crd[a] = 32'hFFFF_FFFF;
              3:       crd[a] = 32'd1;
              default: crd[a] = '0;
            endcase
          end
        endcase
      end
      push_vertex(crd[0], crd[1], crd[2], i == n - 1);
    end
  endtask

  // Wait until all vertices are in and every expected result is out
  task automatic wait_idle();
    while (vertex_queue.size() != 0 || holding || expected_norms.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_box_size(logic [TBS_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    box_size = value;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int               phase_items;
    int               n;
    logic [TBS_W-1:0] rand_sizes[RAND_PHASES];

    box_size = TBS_RESET;
    clear_set_state();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset box size: single vertex, full range, mixed signs, flat set, two flat axes
    push_vertex(32'd0, 32'd0, 32'd0, 1'b1);
    push_vertex(CRD_MIN, CRD_MIN, CRD_MIN, 1'b0);
    push_vertex(CRD_MAX, CRD_MAX, CRD_MAX, 1'b1);
    push_vertex(CRD_MAX, 32'd0, 32'hFFFF_FFFF, 1'b0);
    push_vertex(CRD_MIN, 32'd1, 32'd0, 1'b0);
    push_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_0000, 1'b1);
    push_vertex(32'd5, 32'd5, 32'd5, 1'b0);
    push_vertex(32'd5, 32'd5, 32'd5, 1'b1);
    push_vertex(-32'sd3, 32'd7, 32'd7, 1'b0);
    push_vertex(32'd4, 32'd7, 32'd7, 1'b1);
    wait_idle();

    // Zero box size: outputs collapse to zero without the degenerate flag
    write_box_size('0);
    push_vertex(32'd1, 32'd2, 32'd3, 1'b0);
    push_vertex(-32'sd100, 32'd50, 32'd0, 1'b1);
    wait_idle();

    // Largest box size against full range, unit extent and a single vertex
    write_box_size(TBS_FULL);
    push_vertex(CRD_MIN, 32'd0, 32'd0, 1'b0);
    push_vertex(CRD_MAX, 32'd1, 32'hFFFF_FFFF, 1'b1);
    push_vertex(32'd0, 32'd0, 32'd0, 1'b0);
    push_vertex(32'd1, 32'd0, 32'd0, 1'b1);
    push_vertex(32'd0, 32'd0, 32'd1, 1'b1);
    wait_idle();

    // Random sets under several box sizes; the first phase overfills the store
    rand_sizes[0] = TBS_RESET;
    rand_sizes[1] = TBS_W'($urandom);
    rand_sizes[2] = TBS_W'(1);
    rand_sizes[3] = TBS_FULL;
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_box_size(rand_sizes[p]);
      phase_items = 0;
      if (p == 0) begin
        n = VDEPTH + $urandom_range(1, 4);
        add_random_set(n);
        phase_items += n;
      end
      while (phase_items < PHASE_ITEMS) begin
        n = ($urandom_range(0, 19) == 0) ? VDEPTH - 1 + $urandom_range(0, 2)
                                         : $urandom_range(1, 8);
        add_random_set(n);
        phase_items += n;
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== vertex_unit_box_normalizer.f =====
src/vubn_pkg.sv
src/vubn_ram.sv
src/vubn_queue.sv
src/vubn_front.sv
src/vubn_back.sv
src/vertex_unit_box_normalizer.sv
dv/testbench.sv
